>>> rtl/wpwr_pkg.sv
// ----------------------------------------------------------------------------
// wpwr_pkg
// Shared types and constants for the weighted pick block.
// ----------------------------------------------------------------------------
package wpwr_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int ID_BITS     = 8;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = 6;
    localparam int CUM_BITS    = 21;
    localparam int RND_BITS    = 31;
    localparam int RAM_BITS    = ID_BITS + CUM_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_PICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PICK  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_TOT_RD,
        S_DIV,
        S_SRCH,
        S_SHIFT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the input word
        logic rd_last;    // read entry count-1
        logic app_wr;     // write appended entry
        logic tot_load;   // load total, start remainder
        logic div_step;   // one restoring step
        logic srch_step;  // compare entry, advance
        logic shift_step; // move entry up by one
        logic cnt_clear;
        logic cnt_inc;
        logic cnt_dec;
        logic res_load;   // capture result word
        status_t res_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic empty;
        logic full;
        logic div_done;
        logic hit;        // remainder below current entry, or last entry
        logic shift_done;
    } dp_stat_t;

endpackage

>>> rtl/wpwr_ram.sv
// ----------------------------------------------------------------------------
// wpwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/wpwr_datapath.sv
// ----------------------------------------------------------------------------
// wpwr_datapath
// Entry table, remainder unit, search and compaction registers.
// ----------------------------------------------------------------------------
module wpwr_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wpwr_pkg::dp_cmd_t    cmd,
    output wpwr_pkg::dp_stat_t   stat,
    input  logic [1:0]           in_op,
    input  logic [7:0]           in_id,
    input  logic [15:0]          in_weight,
    input  logic [30:0]          in_rnd,
    output logic [1:0]           res_status,
    output logic [7:0]           res_id,
    output logic [5:0]           res_count
);
    import wpwr_pkg::*;

    logic [1:0]            op_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [IDX_BITS-1:0]   idx_reg;       // search / shift position
    logic [CUM_BITS-1:0]   tot_reg;
    logic [RND_BITS-1:0]   quo_reg;       // dividend bits shifting out
    logic [CUM_BITS:0]     rem_reg;
    logic [4:0]            dstep_reg;
    logic [CUM_BITS-1:0]   base_reg;      // cumulative of previous entry
    logic [CUM_BITS-1:0]   removed_reg;
    logic [ID_BITS-1:0]    pick_reg;
    logic                  shifting_reg;
    logic [1:0]            rs_reg;
    logic [ID_BITS-1:0]    rid_reg;
    logic [CNT_BITS-1:0]   rcnt_reg;

    logic                  we;
    logic [IDX_BITS-1:0]   waddr, raddr;
    logic [RAM_BITS-1:0]   wdata, rdata;
    logic [ID_BITS-1:0]    rd_id;
    logic [CUM_BITS-1:0]   rd_cum;
    logic [CUM_BITS-1:0]   w_ext;
    logic [CUM_BITS:0]     rem_sh, rem_sub;

    assign rd_id  = rdata[RAM_BITS-1 -: ID_BITS];
    assign rd_cum = rdata[CUM_BITS-1:0];
    assign w_ext  = (w_reg == '0) ? CUM_BITS'(1) : CUM_BITS'(w_reg);

    wpwr_ram #(.WIDTH(RAM_BITS), .DEPTH(MAX_ENTRIES)) u_ram (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (raddr), .rdata (rdata)
    );

    // read address: idx by default; count-1 for last entry; idx+1 while
    // searching so data for idx is ready each step; idx+2 while shifting
    always_comb begin
        raddr = idx_reg;
        if (cmd.rd_last) begin
            raddr = cnt_reg[IDX_BITS-1:0] - IDX_BITS'(1);
        end
        if (cmd.srch_step) begin
            raddr = idx_reg + IDX_BITS'(1);
        end
        if (cmd.shift_step) begin
            raddr = idx_reg + IDX_BITS'(2);
        end
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {rd_id, rd_cum - removed_reg};
        if (cmd.app_wr) begin
            we    = 1'b1;
            waddr = cnt_reg[IDX_BITS-1:0];
            wdata = {id_reg, ((cnt_reg == '0) ? '0 : rd_cum) + w_ext};
        end else if (cmd.shift_step && shifting_reg) begin
            we = 1'b1;
        end
    end

    assign rem_sh  = {rem_reg[CUM_BITS-1:0], quo_reg[RND_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, tot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end else if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;
            id_reg <= in_id;
            w_reg  <= in_weight;
            quo_reg <= in_rnd;
            idx_reg <= '0;
            base_reg <= '0;
            shifting_reg <= 1'b0;
        end
        if (cmd.tot_load) begin
            tot_reg   <= (rd_cum == '0) ? CUM_BITS'(1) : rd_cum;
            rem_reg   <= '0;
            dstep_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg   <= rem_sub[CUM_BITS] ? rem_sh : rem_sub;
            quo_reg   <= {quo_reg[RND_BITS-2:0], 1'b0};
            dstep_reg <= dstep_reg + 5'd1;
        end
        if (cmd.srch_step) begin
            if (stat.hit) begin
                pick_reg     <= rd_id;
                removed_reg  <= rd_cum - base_reg;
                shifting_reg <= 1'b1;
            end else begin
                base_reg <= rd_cum;
                idx_reg  <= idx_reg + IDX_BITS'(1);
            end
        end
        if (cmd.shift_step && shifting_reg) begin
            idx_reg <= idx_reg + IDX_BITS'(1);
        end
        if (cmd.res_load) begin
            rs_reg   <= cmd.res_status;
            rid_reg  <= (cmd.res_status == ST_PICK) ? pick_reg : '0;
            // count as it stands after this word
            rcnt_reg <= cmd.cnt_clear ? '0 :
                        cmd.cnt_inc   ? cnt_reg + CNT_BITS'(1) :
                        cmd.cnt_dec   ? cnt_reg - CNT_BITS'(1) : cnt_reg;
        end
    end

    // shift: write at idx the entry read from idx+1 (read issued in the previous cycle)
    assign stat.op         = op_reg;
    assign stat.empty      = (cnt_reg == '0);
    assign stat.full       = (cnt_reg >= CNT_BITS'(MAX_ENTRIES));
    assign stat.div_done   = (dstep_reg == 5'(RND_BITS - 1)) && cmd.div_step;
    assign stat.hit        = (rem_reg[CUM_BITS-1:0] < rd_cum) ||
                             ({1'b0, idx_reg} == cnt_reg - CNT_BITS'(1));
    assign stat.shift_done = ({1'b0, idx_reg} + CNT_BITS'(1) >= cnt_reg - CNT_BITS'(1));

    assign res_status = rs_reg;
    assign res_id     = rid_reg;
    assign res_count  = rcnt_reg;
endmodule

>>> rtl/wpwr_ctrl.sv
// ----------------------------------------------------------------------------
// wpwr_ctrl
// Sequencer for clear, append and pick operations.
// ----------------------------------------------------------------------------
module wpwr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wpwr_pkg::dp_cmd_t   cmd,
    input  wpwr_pkg::dp_stat_t  stat
);
    import wpwr_pkg::*;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   first_reg;   // first search cycle waits for read data

    assign in_ready  = (state_reg == S_IDLE) && !valid_reg;
    assign out_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid && in_ready) state_next = S_DONE;
            S_DONE: begin
                unique case (stat.op)
                    OP_APPEND: state_next = stat.full ? S_IDLE : S_APP_RD;
                    OP_PICK:   state_next = stat.empty ? S_IDLE : S_TOT_RD;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_APP_RD: state_next = S_APP_WR;
            S_APP_WR: state_next = S_IDLE;
            S_TOT_RD: state_next = S_DIV;
            S_DIV:    if (stat.div_done) state_next = S_SRCH;
            S_SRCH:   if (!first_reg && stat.hit) state_next = S_SHIFT;
            S_SHIFT:  if (stat.shift_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.res_status = ST_OK;
        valid_next = valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE: cmd.load = in_valid && in_ready;
            S_DONE: begin
                cmd.rd_last = 1'b1;
                unique case (stat.op)
                    OP_CLEAR: begin
                        cmd.cnt_clear = 1'b1;
                        cmd.res_load = 1'b1;
                        valid_next = 1'b1;
                    end
                    OP_APPEND: if (stat.full) begin
                        cmd.res_load = 1'b1;
                        cmd.res_status = ST_FULL;
                        valid_next = 1'b1;
                    end
                    OP_PICK: if (stat.empty) begin
                        cmd.res_load = 1'b1;
                        cmd.res_status = ST_EMPTY;
                        valid_next = 1'b1;
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        valid_next = 1'b1;
                    end
                endcase
            end
            S_APP_RD: cmd.rd_last = 1'b1;
            S_APP_WR: begin
                cmd.app_wr   = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.res_load = 1'b1;
                valid_next   = 1'b1;
            end
            S_TOT_RD: cmd.tot_load = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_SRCH:   cmd.srch_step = !first_reg;
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done) begin
                    cmd.cnt_dec = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_PICK;
                    valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            first_reg <= (state_reg != S_SRCH) || (state_next == S_SHIFT);
        end
    end
endmodule

>>> rtl/weighted_pick_without_replacement.sv
// ----------------------------------------------------------------------------
// weighted_pick_without_replacement
// Weighted pick without replacement over a cumulative weight table.
// ----------------------------------------------------------------------------
// Sequence (accepting edge to m_tvalid): clear, unused opcode, full append and
//   empty pick answer from the decode state; append reads the last entry, then
//   writes; pick loads the total, forms the remainder, searches and compacts.
// Handshake: one word at a time; the next word is taken in the cycle after
//   the result handshake.
// Reset: aresetn (sync, low) empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module weighted_pick_without_replacement (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // entry_id[7:0], weight[23:8], random_value[54:24]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // picked_id[7:0], remaining_count[13:8]
    output logic [1:0]  m_tuser   // status[1:0]
);
    import wpwr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [1:0] rs;
    logic [7:0] rid;
    logic [5:0] rc;

    wpwr_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (s_tvalid), .in_ready (s_tready),
        .out_valid (m_tvalid), .out_ready (m_tready),
        .cmd (cmd), .stat (stat)
    );

    wpwr_datapath u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .stat (stat),
        .in_op (s_tuser), .in_id (s_tdata[7:0]),
        .in_weight (s_tdata[23:8]), .in_rnd (s_tdata[54:24]),
        .res_status (rs), .res_id (rid), .res_count (rc)
    );

    assign m_tdata = {2'b00, rc, rid};
    assign m_tuser = rs;

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:8] <= 6'd32) else $error("count overflow");
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_pick_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_PICK) |-> m_tdata[7:0] == 8'd0)
        else $error("id on non-pick result");
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for weighted_pick_without_replacement. Words are fed
// from a queue filled up front; a shadow cumulative-weight table predicts
// every result on input acceptance; the monitor checks each output word.
// ----------------------------------------------------------------------------
module tb_top;
    import wpwr_pkg::*;

    typedef struct {
        op_t         op;
        logic [7:0]  id;
        logic [15:0] wgt;
        logic [30:0] rnd;
        bit          hold;  // wait for all results before sending
    } pick_word_t;

    typedef struct {
        status_t     status;
        logic [7:0]  id;
        logic [5:0]  count;
    } pick_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;  // entry_id[7:0], weight[23:8], random_value[54:24]
    logic [1:0]  s_tuser;  // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // picked_id[7:0], remaining_count[13:8]
    logic [1:0]  m_tuser;  // status[1:0]

    weighted_pick_without_replacement uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pick_word_t  word_q[$];
    pick_res_t   want_q[$];
    pick_word_t  cur_word;
    int          errors;
    int          cycles;
    int          in_gap;
    int          out_gap;
    bit          run_started;
    bit          no_idle;
    bit          in_taken;  // current word accepted at the last rising edge

    // shadow table
    logic [7:0]  tbl_id[MAX_ENTRIES];
    logic [20:0] tbl_cum[MAX_ENTRIES];
    int          tbl_cnt;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // apply one accepted word to the shadow table, return its result
    function automatic pick_res_t apply_word(pick_word_t w);
        pick_res_t   res;
        logic [20:0] total, rem, base, removed;
        logic [15:0] wt;
        int          sel;
        res.status = ST_OK;
        res.id     = '0;
        case (w.op)
            OP_CLEAR: begin
                tbl_cnt = 0;
            end
            OP_APPEND: begin
                if (tbl_cnt >= MAX_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    wt = (w.wgt == 0) ? 16'd1 : w.wgt;
                    base = (tbl_cnt > 0) ? tbl_cum[tbl_cnt-1] : 21'd0;
                    tbl_id[tbl_cnt]  = w.id;
                    tbl_cum[tbl_cnt] = base + wt;
                    tbl_cnt++;
                end
            end
            OP_PICK: begin
                if (tbl_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    total = tbl_cum[tbl_cnt-1];
                    rem   = 21'(w.rnd % 31'(total));
                    sel   = tbl_cnt - 1;
                    for (int i = tbl_cnt - 1; i >= 0; i--)
                        if (rem < tbl_cum[i]) sel = i;
                    res.status = ST_PICK;
                    res.id     = tbl_id[sel];
                    base    = (sel > 0) ? tbl_cum[sel-1] : 21'd0;
                    removed = tbl_cum[sel] - base;
                    for (int i = sel; i + 1 < tbl_cnt; i++) begin
                        tbl_id[i]  = tbl_id[i+1];
                        tbl_cum[i] = tbl_cum[i+1] - removed;
                    end
                    tbl_cnt--;
                end
            end
            default: ;  // unused opcode: no change
        endcase
        res.count = 6'(tbl_cnt);
        return res;
    endfunction

    function automatic pick_word_t mk_word(op_t op, logic [7:0] id, logic [15:0] wgt,
                                          logic [30:0] rnd);
        pick_word_t w;
        w.op = op; w.id = id; w.wgt = wgt; w.rnd = rnd; w.hold = 1'b0;
        return w;
    endfunction

    // random word: appends and picks dominate, clears and unused opcode rare
    function automatic pick_word_t rand_word();
        int r;
        op_t op;
        logic [15:0] wgt;
        r = $urandom_range(99);
        if (r < 3)       op = OP_CLEAR;
        else if (r < 6)  op = OP_NONE;
        else if (r < 53) op = OP_APPEND;
        else             op = OP_PICK;
        r = $urandom_range(9);
        if (r < 4)      wgt = 16'($urandom_range(15));
        else if (r < 5) wgt = (r[0]) ? 16'hFFFF : 16'd0;
        else            wgt = 16'($urandom);
        return mk_word(op, 8'($urandom), wgt, 31'($urandom));
    endfunction

    // stimulus
    initial begin
        pick_word_t w;
        // directed: empty pick, extremes of every field, fill to full and beyond
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0000, 31'h0));
        word_q.push_back(mk_word(OP_NONE, 8'hFF, 16'hFFFF, 31'h7FFFFFFF));
        word_q.push_back(mk_word(OP_APPEND, 8'h00, 16'h0000, 31'h7FFFFFFF));
        word_q.push_back(mk_word(OP_APPEND, 8'hFF, 16'hFFFF, 31'h0));
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0, 31'h0));
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0, 31'h7FFFFFFF));
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0, 31'h0));
        for (int i = 0; i < MAX_ENTRIES + 2; i++)
            word_q.push_back(mk_word(OP_APPEND, 8'(i * 7), 16'hFFFF - 16'(i),
                                     31'($urandom)));
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0, 31'h7FFFFFFF));
        word_q.push_back(mk_word(OP_NONE, 8'h00, 16'h0, 31'h0));
        word_q.push_back(mk_word(OP_CLEAR, 8'hFF, 16'hFFFF, 31'h7FFFFFFF));
        word_q.push_back(mk_word(OP_PICK, 8'h00, 16'h0, 31'h12345));
        for (int i = 0; i < 1400; i++) begin
            w = rand_word();
            if (i == 700) w.hold = 1'b1;  // sender drains the block once
            word_q.push_back(w);
        end
    end

    // reset and end of run
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        errors   = 0;
        cycles   = 0;
        in_gap   = 0;
        out_gap  = 0;
        tbl_cnt  = 0;
        no_idle  = 1'b0;
        in_taken = 1'b0;
        run_started = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run_started = 1'b1;
        wait (word_q.size() == 0 && !s_tvalid && want_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // input acceptance: predict here, in acceptance order
    always @(posedge aclk) begin
        if (run_started && s_tvalid && s_tready) begin
            want_q.push_back(apply_word(cur_word));
            in_taken = 1'b1;
        end
    end

    // input driver, falling edge
    always @(negedge aclk) begin
        if (run_started && (!s_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (word_q.size() > 0 && !(word_q[0].hold && want_q.size() > 0)) begin
                cur_word = word_q.pop_front();
                s_tdata  <= {1'b0, cur_word.rnd, cur_word.wgt, cur_word.id};
                s_tuser  <= cur_word.op;
                s_tvalid <= 1'b1;
                in_gap   <= draw_gap();
                if (word_q.size() % 300 == 0) no_idle = ~no_idle;  // idle-free stretches
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure, falling edge
    always @(negedge aclk) begin
        if (run_started) begin
            if (out_gap > 0) begin
                out_gap  <= out_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                out_gap  <= draw_gap();
            end
        end
    end

    // monitor: compare each output word with the oldest prediction
    always @(posedge aclk) begin
        pick_res_t want;
        if (run_started && m_tvalid && m_tready) begin
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h/%h", $time,
                         m_tuser, m_tdata);
            end else begin
                want = want_q.pop_front();
                if (m_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d", $time, want.status,
                             m_tuser);
                end
                if (m_tdata[7:0] !== want.id) begin
                    errors++;
                    $display("%0t: picked_id expected %0d, got %0d", $time, want.id,
                             m_tdata[7:0]);
                end
                if (m_tdata[13:8] !== want.count) begin
                    errors++;
                    $display("%0t: remaining_count expected %0d, got %0d", $time,
                             want.count, m_tdata[13:8]);
                end
            end
        end
    end

endmodule
